>>> rtl/owi_pkg.sv
package owi_pkg;

    // Width of the word fields on the ports.
    localparam int DATA_BITS = 64;
    // Width of the field length and offset registers.
    localparam int CFG_BITS  = 6;

    // Configuration register indexes.
    localparam logic CFG_FIELD_LENGTH = 1'b0;
    localparam logic CFG_FIELD_OFFSET = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_BITS-1:0] FIELD_LENGTH_RST = CFG_BITS'(1);
    localparam logic [CFG_BITS-1:0] FIELD_OFFSET_RST = CFG_BITS'(0);

    // Operation codes carried in the mode field.
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_FIRST   = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_UPDATED   = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    typedef struct packed {
        logic [CFG_BITS-1:0] field_length;
        logic [CFG_BITS-1:0] field_offset;
    } t_field_cfg;

endpackage

>>> rtl/owi_if.sv
interface owi_in_if import owi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] word_in;
    logic                 mode;

    modport source (output valid, output word_in, output mode, input ready);
    modport sink   (input valid, input word_in, input mode, output ready);
endinterface

interface owi_out_if import owi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] word_out;
    logic [1:0]           status;

    modport source (output valid, output word_out, output status, input ready);
    modport sink   (input valid, input word_out, input status, output ready);
endinterface

interface owi_cfg_if import owi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                index;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/odd_weight_field_iterator.sv
// A beat that is accepted is captured in the input register and then moves
// into the result register, which drives the output.
// Throughput: one beat per cycle while o_out is ready; the input and result
// registers form a two-stage pipeline, so a beat is taken while a result waits.
// Reset (synchronous, active low) empties both stages and loads field_length
// with 1 and field_offset with 0.
module odd_weight_field_iterator
    import owi_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    owi_cfg_if.sink  i_cfg,
    owi_in_if.sink   i_in,
    owi_out_if.source o_out
);

    localparam int LW = $clog2(WORD_BITS + 1);
    // Wide enough to hold any offset and the word width itself.
    localparam int CW = (LW > CFG_BITS) ? LW + 1 : CFG_BITS + 1;

    t_field_cfg cfg;

    // Input register stage.
    logic                 r_in_valid;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_mode;

    // Result register stage.
    logic                 r_out_valid;
    logic [DATA_BITS-1:0] r_word_out;
    logic [1:0]           r_status;

    logic                 out_free;
    logic                 in_take;
    logic                 move;

    logic [CW-1:0]        off_w;
    logic [CW-1:0]        len_w;
    logic [CW-1:0]        room;
    logic [CW-1:0]        len_clip;
    logic [LW-1:0]        len_eff;

    logic [WORD_BITS-1:0] field_raw;
    logic [WORD_BITS-1:0] fmask;
    logic [WORD_BITS-1:0] next_field;
    logic [1:0]           status;
    logic [WORD_BITS-1:0] n_word;

    owi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // The result register frees up when it is empty or being read this cycle.
    // The input stage moves into it whenever it is free, and the input side
    // takes a new beat whenever its own register empties at the same edge.
    assign out_free    = !r_out_valid || o_out.ready;
    assign move        = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || out_free;
    assign in_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Bits at and above the word width are dropped on the way in.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_in.word_in[WORD_BITS-1:0];
            r_mode <= i_in.mode;
        end
    end

    // The field is clipped to the word. An offset at or past the word width
    // leaves an empty field, which reports the sequence as exhausted.
    assign off_w    = CW'(cfg.field_offset);
    assign len_w    = CW'(cfg.field_length);
    assign room     = CW'(WORD_BITS) - off_w;
    assign len_clip = (off_w >= CW'(WORD_BITS)) ? '0 :
                      ((len_w > room) ? room : len_w);
    assign len_eff  = LW'(len_clip);

    assign field_raw = r_word >> cfg.field_offset;

    owi_next_vec #(
        .W (WORD_BITS)
    ) u_next (
        .i_field_raw (field_raw),
        .i_len       (len_eff),
        .i_mode      (r_mode),
        .o_fmask     (fmask),
        .o_next      (next_field),
        .o_status    (status)
    );

    // Only a successful update touches the word; bits outside the field stay.
    always_comb begin
        n_word = r_word;
        if (status == STATUS_UPDATED) begin
            n_word = (r_word & ~(fmask << cfg.field_offset)) |
                     ((next_field & fmask) << cfg.field_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Upper bits beyond the word width read as zero.
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_word_out <= DATA_BITS'(n_word);
            r_status   <= status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.word_out = r_word_out;
    assign o_out.status   = r_status;

endmodule

>>> rtl/owi_cfg_regs.sv
module owi_cfg_regs
    import owi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    owi_cfg_if.sink     i_cfg,
    output t_field_cfg  o_cfg
);

    logic [CFG_BITS-1:0] r_field_length;
    logic [CFG_BITS-1:0] r_field_offset;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_length <= FIELD_LENGTH_RST;
            r_field_offset <= FIELD_OFFSET_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FIELD_LENGTH: r_field_length <= i_cfg.data;
                CFG_FIELD_OFFSET: r_field_offset <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg.field_length = r_field_length;
    assign o_cfg.field_offset = r_field_offset;

endmodule

>>> rtl/owi_next_vec.sv
module owi_next_vec
    import owi_pkg::*;
#(
    parameter int W = 64
) (
    input  logic [W-1:0]         i_field_raw,
    input  logic [$clog2(W+1)-1:0] i_len,
    input  logic                 i_mode,
    output logic [W-1:0]         o_fmask,
    output logic [W-1:0]         o_next,
    output logic [1:0]           o_status
);

    localparam int LW  = $clog2(W+1);
    localparam int TZW = $clog2(W);

    logic [W-1:0]   fmask;
    logic [W-1:0]   x;
    logic [W-1:0]   low_bit;
    logic [TZW-1:0] tz;
    logic           packed_top;
    logic [W:0]     ripple;
    logic [W:0]     moved;
    logic [W:0]     moved_sh;
    logic [W-1:0]   gosper;
    logic [LW:0]    wt_plus2;
    logic [W-1:0]   low_ones;

    always_comb begin
        for (int i = 0; i < W; i++) begin
            fmask[i] = (LW'(i) < i_len);
        end
    end

    assign x       = i_field_raw & fmask;
    // Isolate the lowest set bit; its position is an OR of the indexes.
    assign low_bit = x & (~x + W'(1));

    always_comb begin
        tz = '0;
        for (int i = 0; i < W; i++) begin
            if (low_bit[i]) begin
                tz = tz | TZW'(i);
            end
        end
    end

    // Ones sit at the top of the field when filling the zeros below the lowest
    // one gives the whole field.
    assign packed_top = ((x | (x - W'(1))) == fmask);

    // Next combination of the same weight.
    assign ripple   = {1'b0, x} + {1'b0, low_bit};
    assign moved    = {1'b0, x} ^ ripple;
    assign moved_sh = (moved >> tz) >> 2;
    assign gosper   = (ripple[W-1:0] | moved_sh[W-1:0]) & fmask;

    // Weight plus two equals length minus trailing zeros plus two.
    assign wt_plus2 = (LW+1)'(i_len) - (LW+1)'(tz) + (LW+1)'(2);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            low_ones[i] = ((LW+1)'(i) < wt_plus2);
        end
    end

    always_comb begin
        o_next   = '0;
        o_status = STATUS_UPDATED;
        if (i_len == '0) begin
            o_status = STATUS_EXHAUSTED;
        end else if (i_mode == MODE_FIRST) begin
            o_next = W'(1);
        end else if (x == '0) begin
            o_status = STATUS_MALFORMED;
        end else if (packed_top) begin
            // A weight of at least length minus one leaves no room for two more ones.
            if (tz <= TZW'(1)) begin
                o_status = STATUS_EXHAUSTED;
            end else begin
                o_next = low_ones & fmask;
            end
        end else begin
            o_next = gosper;
        end
    end

    assign o_fmask = fmask;

endmodule
